/* design/ffilt_pkg.sv */
// Shared types, constants and field codes of the flow record field filter.
package ffilt_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_ADDR  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_MASK  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_ADDR  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_MASK  = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_START = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WIN_STOP  = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_PORT  = 8'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_PORT  = 8'd7;

    // Template field type codes.
    localparam logic [15:0] FT_L4_SRC_PORT   = 16'd7;
    localparam logic [15:0] FT_IPV4_SRC_ADDR = 16'd8;
    localparam logic [15:0] FT_L4_DST_PORT   = 16'd11;
    localparam logic [15:0] FT_IPV4_DST_ADDR = 16'd12;
    localparam logic [15:0] FT_LAST_SWITCHED = 16'd21;
    localparam logic [15:0] FT_FIRST_SWITCHED = 16'd22;

    localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
    localparam logic [15:0] ALL_ONES16 = 16'hFFFF;

    // Millisecond to second conversion by reciprocal multiplication.
    // The magnitude never exceeds 2^31, well inside the exact range of this
    // reciprocal.
    localparam longint unsigned MS_PER_SECOND = 1000;
    localparam int unsigned     DIV_SHIFT     = 38;
    localparam int unsigned     RECIP_W       = 29;
    localparam int unsigned     QUOT_W        = 32 + RECIP_W - DIV_SHIFT;
    localparam logic [RECIP_W-1:0] DIV_RECIP =
        RECIP_W'(((64'd1 << DIV_SHIFT) + MS_PER_SECOND - 64'd1) / MS_PER_SECOND);

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [31:0] win_start;
        logic [31:0] win_stop;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } t_cfg;

    // Per-field check outcome handed from the check pipeline to the verdict stage.
    typedef struct packed {
        logic fail;
        logic last;
    } t_item;

endpackage

/* design/ffilt_cfg.sv */
// Configuration register file of the flow record field filter.
module ffilt_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ffilt_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [ffilt_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output ffilt_pkg::t_cfg                    o_cfg
);

    ffilt_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_addr  <= ffilt_pkg::ALL_ONES32;
            r_cfg.src_mask  <= ffilt_pkg::ALL_ONES32;
            r_cfg.dst_addr  <= ffilt_pkg::ALL_ONES32;
            r_cfg.dst_mask  <= ffilt_pkg::ALL_ONES32;
            r_cfg.win_start <= ffilt_pkg::ALL_ONES32;
            r_cfg.win_stop  <= ffilt_pkg::ALL_ONES32;
            r_cfg.src_port  <= ffilt_pkg::ALL_ONES16;
            r_cfg.dst_port  <= ffilt_pkg::ALL_ONES16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ffilt_pkg::REG_SRC_ADDR:  r_cfg.src_addr  <= i_cfg_data;
                ffilt_pkg::REG_SRC_MASK:  r_cfg.src_mask  <= i_cfg_data;
                ffilt_pkg::REG_DST_ADDR:  r_cfg.dst_addr  <= i_cfg_data;
                ffilt_pkg::REG_DST_MASK:  r_cfg.dst_mask  <= i_cfg_data;
                ffilt_pkg::REG_WIN_START: r_cfg.win_start <= i_cfg_data;
                ffilt_pkg::REG_WIN_STOP:  r_cfg.win_stop  <= i_cfg_data;
                ffilt_pkg::REG_SRC_PORT:  r_cfg.src_port  <= i_cfg_data[15:0];
                ffilt_pkg::REG_DST_PORT:  r_cfg.dst_port  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

/* design/ffilt_pipe.sv */
// Three-stage check pipeline: input, delta checks, time quotient; then verdict.
module ffilt_pipe (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ffilt_pkg::t_cfg  i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [15:0]      i_field_type,
    input  logic [31:0]      i_field_value,
    input  logic [31:0]      i_sys_uptime,
    input  logic [31:0]      i_export_seconds,
    input  logic             i_last_field,
    output logic             o_item_valid,
    input  logic             i_item_ready,
    output ffilt_pkg::t_item o_item
);

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FIRST,
        KIND_LAST
    } t_kind;

    // Stage 1: input register.
    logic        r_s1_valid;
    logic [15:0] r_s1_type;
    logic [31:0] r_s1_value;
    logic [31:0] r_s1_uptime;
    logic [31:0] r_s1_secs;
    logic        r_s1_last;

    // Stage 2: delta magnitude and the checks that need no time.
    logic        r_s2_valid;
    logic [31:0] r_s2_mag;
    logic        r_s2_neg;
    logic [31:0] r_s2_secs;
    t_kind       r_s2_kind;
    logic        r_s2_fail;
    logic        r_s2_last;

    // Stage 3: whole seconds of the delta.
    logic                          r_s3_valid;
    logic [ffilt_pkg::QUOT_W-1:0]  r_s3_quot;
    logic                          r_s3_neg;
    logic [31:0]                   r_s3_secs;
    t_kind                         r_s3_kind;
    logic                          r_s3_fail;
    logic                          r_s3_last;

    logic s1_ready, s2_ready, s3_ready;

    logic [31:0] diff;
    logic [31:0] mag;
    t_kind       kind;
    logic        static_fail;
    logic [31+ffilt_pkg::RECIP_W:0] prod;
    logic [31:0] flow_secs;
    logic        time_fail;

    assign s3_ready = !r_s3_valid || i_item_ready;
    assign s2_ready = !r_s2_valid || s3_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    always_comb begin
        diff        = r_s1_value - r_s1_uptime;
        mag         = diff[31] ? (~diff + 32'd1) : diff;
        kind        = KIND_NONE;
        static_fail = 1'b0;
        case (r_s1_type)
            ffilt_pkg::FT_IPV4_SRC_ADDR: begin
                if (i_cfg.src_addr != ffilt_pkg::ALL_ONES32) begin
                    static_fail = ((r_s1_value & i_cfg.src_mask) !=
                                   (i_cfg.src_addr & i_cfg.src_mask)) ||
                                  (r_s1_value < i_cfg.src_addr);
                end
            end
            ffilt_pkg::FT_IPV4_DST_ADDR: begin
                if (i_cfg.dst_addr != ffilt_pkg::ALL_ONES32) begin
                    static_fail = ((r_s1_value & i_cfg.dst_mask) !=
                                   (i_cfg.dst_addr & i_cfg.dst_mask)) ||
                                  (r_s1_value < i_cfg.dst_addr);
                end
            end
            ffilt_pkg::FT_L4_SRC_PORT: begin
                if (i_cfg.src_port != ffilt_pkg::ALL_ONES16) begin
                    static_fail = r_s1_value[15:0] != i_cfg.src_port;
                end
            end
            ffilt_pkg::FT_L4_DST_PORT: begin
                if (i_cfg.dst_port != ffilt_pkg::ALL_ONES16) begin
                    static_fail = r_s1_value[15:0] != i_cfg.dst_port;
                end
            end
            ffilt_pkg::FT_FIRST_SWITCHED: kind = KIND_FIRST;
            ffilt_pkg::FT_LAST_SWITCHED:  kind = KIND_LAST;
            default: ;
        endcase
    end

    assign prod = {{ffilt_pkg::RECIP_W{1'b0}}, r_s2_mag} *
                  {32'd0, ffilt_pkg::DIV_RECIP};

    always_comb begin
        // Truncation toward zero: divide the magnitude, then apply the sign.
        if (r_s3_neg) begin
            flow_secs = r_s3_secs - {{(32-ffilt_pkg::QUOT_W){1'b0}}, r_s3_quot};
        end else begin
            flow_secs = r_s3_secs + {{(32-ffilt_pkg::QUOT_W){1'b0}}, r_s3_quot};
        end
        time_fail = 1'b0;
        case (r_s3_kind)
            KIND_FIRST: time_fail = (i_cfg.win_start != ffilt_pkg::ALL_ONES32) &&
                                    (i_cfg.win_start > flow_secs);
            KIND_LAST:  time_fail = (i_cfg.win_stop != ffilt_pkg::ALL_ONES32) &&
                                    (i_cfg.win_stop < flow_secs);
            default:    time_fail = 1'b0;
        endcase
    end

    assign o_item_valid = r_s3_valid;
    assign o_item.fail  = r_s3_fail || time_fail;
    assign o_item.last  = r_s3_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s3_ready) begin
                r_s3_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_type   <= i_field_type;
            r_s1_value  <= i_field_value;
            r_s1_uptime <= i_sys_uptime;
            r_s1_secs   <= i_export_seconds;
            r_s1_last   <= i_last_field;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_mag  <= mag;
            r_s2_neg  <= diff[31];
            r_s2_secs <= r_s1_secs;
            r_s2_kind <= kind;
            r_s2_fail <= static_fail;
            r_s2_last <= r_s1_last;
        end
        if (s3_ready && r_s2_valid) begin
            r_s3_quot <= prod[31+ffilt_pkg::RECIP_W:ffilt_pkg::DIV_SHIFT];
            r_s3_neg  <= r_s2_neg;
            r_s3_secs <= r_s2_secs;
            r_s3_kind <= r_s2_kind;
            r_s3_fail <= r_s2_fail;
            r_s3_last <= r_s2_last;
        end
    end

endmodule

/* design/flow_record_field_filter_top.sv */
// A record's verdict reaches m_axis through a three-stage check pipeline and a result register.
// Throughput: one field beat per cycle, unless a last field waits on an unread result register.
// Fields that are not last leave no result and never wait for the output side.
// Reset (synchronous, active low) empties the pipeline, clears the drop flag and
// sets every configuration register to all ones, which disables every check.
module flow_record_field_filter_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ffilt_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [ffilt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // field_type[15:0], field_value[47:16], sys_uptime[79:48], export_seconds[111:80]
    input  logic [111:0]                      s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // record_pass[0], zero fill [7:1]
    output logic [7:0]                        m_axis_tdata
);

    ffilt_pkg::t_cfg  cfg;
    ffilt_pkg::t_item item;
    logic             item_valid;
    logic             item_ready;
    logic             item_take;

    logic r_drop;
    logic r_out_valid;
    logic r_out_pass;
    logic n_drop;

    ffilt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ffilt_pipe u_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_field_type     (s_axis_tdata[15:0]),
        .i_field_value    (s_axis_tdata[47:16]),
        .i_sys_uptime     (s_axis_tdata[79:48]),
        .i_export_seconds (s_axis_tdata[111:80]),
        .i_last_field     (s_axis_tlast),
        .o_item_valid     (item_valid),
        .i_item_ready     (item_ready),
        .o_item           (item)
    );

    // Only a last field needs room in the result register.
    assign item_ready = !item.last || !r_out_valid || m_axis_tready;
    assign item_take  = item_valid && item_ready;
    assign n_drop     = r_drop || item.fail;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_pass};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (item_take) begin
                if (item.last) begin
                    r_out_valid <= 1'b1;
                    r_drop      <= 1'b0;
                end else begin
                    r_drop <= n_drop;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_take && item.last) begin
            r_out_pass <= !n_drop;
        end
    end

    a_drop_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_take && item.last |=> !r_drop)
        else $error("drop flag survived the end of a record");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(item_take && item.last))
        else $error("result appeared without a last field");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_take && item.last |-> !r_out_valid || m_axis_tready)
        else $error("pending result overwritten");

    a_fail_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        item_take && !item.last && item.fail |=> r_drop)
        else $error("failed check not remembered");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the flow record field filter: directed and random field streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MILLIS_PER_SEC = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_PERCENT   = 13;
    localparam int PHASE_FIELDS   = 240;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [ffilt_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_LOW  = 8'd8;
    localparam logic [ffilt_pkg::CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = 8'hFF;

    typedef struct packed {
        logic        last;
        logic [31:0] secs;
        logic [31:0] uptime;
        logic [31:0] value;
        logic [15:0] ftype;
    } t_field_beat;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [ffilt_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [ffilt_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [111:0]                      s_axis_tdata = '0;
    logic                              s_axis_tlast = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [7:0]                        m_axis_tdata;

    flow_record_field_filter_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    t_field_beat     field_queue[$];
    logic            verdicts_due[$];
    ffilt_pkg::t_cfg filter_cfg = '1;
    logic            drop_seen = 1'b0;
    t_field_beat     on_bus;
    int              fields_queued = 0;
    int              fields_taken = 0;
    int              idle_pct = IDLE_PERCENT;
    int              hold_requests = 0;
    int              hold_served = 0;
    int              hold_left = 0;
    int              error_count = 0;
    int              records_passed = 0;
    int              records_dropped = 0;

    function automatic logic [31:0] to_unix_seconds(logic [31:0] value, logic [31:0] uptime,
                                                    logic [31:0] secs);
        logic [31:0] diff;
        int          millis;
        int          whole;
        diff   = value - uptime;
        millis = signed'(diff);
        whole  = millis / MILLIS_PER_SEC;
        return secs + 32'(whole);
    endfunction

    function automatic logic address_rejected(logic [31:0] v, logic [31:0] addr,
                                              logic [31:0] mask);
        return ((v & mask) != (addr & mask)) || (v < addr);
    endfunction

    function automatic logic field_rejected(t_field_beat b);
        logic [31:0] t;
        t = to_unix_seconds(b.value, b.uptime, b.secs);
        case (b.ftype)
            ffilt_pkg::FT_IPV4_SRC_ADDR: if (filter_cfg.src_addr != ffilt_pkg::ALL_ONES32)
                return address_rejected(b.value, filter_cfg.src_addr, filter_cfg.src_mask);
            ffilt_pkg::FT_IPV4_DST_ADDR: if (filter_cfg.dst_addr != ffilt_pkg::ALL_ONES32)
                return address_rejected(b.value, filter_cfg.dst_addr, filter_cfg.dst_mask);
            ffilt_pkg::FT_FIRST_SWITCHED: if (filter_cfg.win_start != ffilt_pkg::ALL_ONES32)
                return filter_cfg.win_start > t;
            ffilt_pkg::FT_LAST_SWITCHED: if (filter_cfg.win_stop != ffilt_pkg::ALL_ONES32)
                return filter_cfg.win_stop < t;
            ffilt_pkg::FT_L4_SRC_PORT: if (filter_cfg.src_port != ffilt_pkg::ALL_ONES16)
                return b.value[15:0] != filter_cfg.src_port;
            ffilt_pkg::FT_L4_DST_PORT: if (filter_cfg.dst_port != ffilt_pkg::ALL_ONES16)
                return b.value[15:0] != filter_cfg.dst_port;
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Field sender: predicts each beat as it is taken, then offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                fields_taken++;
                if (field_rejected(on_bus))
                    drop_seen = 1'b1;
                if (on_bus.last) begin
                    verdicts_due.push_back(!drop_seen);
                    drop_seen = 1'b0;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (field_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    on_bus = field_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {on_bus.secs, on_bus.uptime, on_bus.value, on_bus.ftype};
                    s_axis_tlast  <= on_bus.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Verdict receiver: random back-pressure plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ffilt_pkg::REG_SRC_ADDR:  filter_cfg.src_addr  = i_cfg_data;
                    ffilt_pkg::REG_SRC_MASK:  filter_cfg.src_mask  = i_cfg_data;
                    ffilt_pkg::REG_DST_ADDR:  filter_cfg.dst_addr  = i_cfg_data;
                    ffilt_pkg::REG_DST_MASK:  filter_cfg.dst_mask  = i_cfg_data;
                    ffilt_pkg::REG_WIN_START: filter_cfg.win_start = i_cfg_data;
                    ffilt_pkg::REG_WIN_STOP:  filter_cfg.win_stop  = i_cfg_data;
                    ffilt_pkg::REG_SRC_PORT:  filter_cfg.src_port  = i_cfg_data[15:0];
                    ffilt_pkg::REG_DST_PORT:  filter_cfg.dst_port  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("record_pass: unexpected beat, actual %0d", m_axis_tdata[0]);
                    error_count++;
                end else begin
                    logic wanted;
                    wanted = verdicts_due.pop_front();
                    if (m_axis_tdata[0] !== wanted) begin
                        $error("record_pass mismatch: expected %0d, actual %0d",
                               wanted, m_axis_tdata[0]);
                        error_count++;
                    end
                    if (wanted)
                        records_passed++;
                    else
                        records_dropped++;
                end
            end
        end
    end

    task automatic write_reg(logic [ffilt_pkg::CFG_INDEX_W-1:0] index, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Upper bits of the port writes are random; only the low half should land.
    task automatic load_filter(ffilt_pkg::t_cfg c);
        write_reg(ffilt_pkg::REG_SRC_ADDR, c.src_addr);
        write_reg(ffilt_pkg::REG_SRC_MASK, c.src_mask);
        write_reg(ffilt_pkg::REG_DST_ADDR, c.dst_addr);
        write_reg(ffilt_pkg::REG_DST_MASK, c.dst_mask);
        write_reg(ffilt_pkg::REG_WIN_START, c.win_start);
        write_reg(ffilt_pkg::REG_WIN_STOP, c.win_stop);
        write_reg(ffilt_pkg::REG_SRC_PORT, {16'($urandom), c.src_port});
        write_reg(ffilt_pkg::REG_DST_PORT, {16'($urandom), c.dst_port});
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_field(logic [15:0] ftype, logic [31:0] value, logic [31:0] uptime,
                             logic [31:0] secs, logic last);
        t_field_beat b;
        b = '{last: last, secs: secs, uptime: uptime, value: value, ftype: ftype};
        field_queue.push_back(b);
        fields_queued++;
    endtask

    task automatic wait_drained();
        while (fields_taken != fields_queued || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] near_address(logic [31:0] addr, logic [31:0] mask);
        case ($urandom_range(0, 4))
            0: return addr;
            1: return (addr & mask) | ($urandom & ~mask);
            2: return addr + $urandom_range(0, 3) - 32'd1;
            3: return $urandom;
            default: return (addr & mask) | (~mask & {32{$urandom_range(0, 1) == 1}});
        endcase
    endfunction

    // A timestamp whose converted seconds mostly land close to the given window bound.
    task automatic add_time_field(logic [15:0] ftype, logic [31:0] bound, logic last);
        int          offset_ms;
        logic [31:0] uptime;
        logic [31:0] secs;
        uptime = $urandom;
        if ($urandom_range(0, 3) == 0)
            offset_ms = $urandom;
        else
            offset_ms = int'($urandom_range(0, 20000)) - 10000;
        secs = bound - 32'(offset_ms / MILLIS_PER_SEC) + $urandom_range(0, 4) - 32'd2;
        if ($urandom_range(0, 9) == 0)
            secs = $urandom;
        add_field(ftype, uptime + 32'(offset_ms), uptime, secs, last);
    endtask

    function automatic logic [15:0] near_port(logic [15:0] port);
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : port;
    endfunction

    task automatic add_random_record(ffilt_pkg::t_cfg plan, int max_len);
        int   len;
        logic last;
        len = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++) begin
            last = (i == len - 1);
            case ($urandom_range(0, 7))
                0: add_field(ffilt_pkg::FT_IPV4_SRC_ADDR,
                             near_address(plan.src_addr, plan.src_mask),
                             $urandom, $urandom, last);
                1: add_field(ffilt_pkg::FT_IPV4_DST_ADDR,
                             near_address(plan.dst_addr, plan.dst_mask),
                             $urandom, $urandom, last);
                2: add_time_field(ffilt_pkg::FT_FIRST_SWITCHED, plan.win_start, last);
                3: add_time_field(ffilt_pkg::FT_LAST_SWITCHED, plan.win_stop, last);
                4: add_field(ffilt_pkg::FT_L4_SRC_PORT,
                             {16'($urandom), near_port(plan.src_port)},
                             $urandom, $urandom, last);
                5: add_field(ffilt_pkg::FT_L4_DST_PORT,
                             {16'($urandom), near_port(plan.dst_port)},
                             $urandom, $urandom, last);
                6: add_field(16'($urandom_range(0, 65535)), $urandom, $urandom, $urandom, last);
                default: add_field(16'($urandom_range(0, 31)), $urandom, $urandom, $urandom,
                                   last);
            endcase
        end
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 9))
            0, 1: return ffilt_pkg::ALL_ONES32;
            2: return 32'd0;
            3: return 32'hFFFF_FFFE;
            default: return $urandom;
        endcase
    endfunction

    function automatic ffilt_pkg::t_cfg random_filter();
        ffilt_pkg::t_cfg c;
        c.src_addr  = random_word();
        c.src_mask  = ($urandom_range(0, 1) == 1) ?
                      ffilt_pkg::ALL_ONES32 << $urandom_range(0, 32) : random_word();
        c.dst_addr  = random_word();
        c.dst_mask  = ($urandom_range(0, 1) == 1) ?
                      ffilt_pkg::ALL_ONES32 << $urandom_range(0, 32) : random_word();
        c.win_start = random_word();
        c.win_stop  = ($urandom_range(0, 2) == 0) ? random_word()
                                                  : c.win_start + $urandom_range(0, 100000);
        c.src_port  = ($urandom_range(0, 4) == 0) ? ffilt_pkg::ALL_ONES16 : 16'($urandom);
        c.dst_port  = ($urandom_range(0, 4) == 0) ? ffilt_pkg::ALL_ONES16 : 16'($urandom);
        return c;
    endfunction

    task automatic run_random_phase(ffilt_pkg::t_cfg plan, int fields, int max_len);
        int start;
        load_filter(plan);
        start = fields_queued;
        while (fields_queued - start < fields)
            add_random_record(plan, max_len);
        wait_drained();
    endtask

    initial begin
        ffilt_pkg::t_cfg plan;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset every check is disabled, so any record passes.
        add_field(ffilt_pkg::FT_L4_SRC_PORT, 32'd0, 32'd0, 32'd0, 1'b0);
        add_field(ffilt_pkg::FT_IPV4_SRC_ADDR, ffilt_pkg::ALL_ONES32, ffilt_pkg::ALL_ONES32,
                  ffilt_pkg::ALL_ONES32, 1'b0);
        add_field(ffilt_pkg::FT_L4_DST_PORT, ffilt_pkg::ALL_ONES32, 32'd0,
                  ffilt_pkg::ALL_ONES32, 1'b0);
        add_field(ffilt_pkg::FT_IPV4_DST_ADDR, 32'd0, ffilt_pkg::ALL_ONES32, 32'd0, 1'b0);
        add_field(ffilt_pkg::FT_FIRST_SWITCHED, 32'd0, ffilt_pkg::ALL_ONES32, 32'd0, 1'b0);
        add_field(ffilt_pkg::FT_LAST_SWITCHED, ffilt_pkg::ALL_ONES32, 32'd0,
                  ffilt_pkg::ALL_ONES32, 1'b0);
        add_field(16'h0000, $urandom, $urandom, $urandom, 1'b0);
        add_field(16'hFFFF, $urandom, $urandom, $urandom, 1'b1);
        wait_drained();

        plan = '{src_addr: 32'h0A01_0205, src_mask: 32'hFFFF_FF00,
                 dst_addr: 32'hC0A8_0000, dst_mask: 32'hFFFF_0000,
                 win_start: 32'd1_000_000, win_stop: 32'd1_000_100,
                 src_port: 16'd80, dst_port: 16'd443};
        load_filter(plan);
        write_reg(REG_UNMAPPED_LOW, 32'd0);
        write_reg(REG_UNMAPPED_HIGH, 32'd0);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);

        add_field(ffilt_pkg::FT_IPV4_SRC_ADDR, 32'h0A01_0205, 32'd0, 32'd0, 1'b1);
        // Same subnet but numerically below the configured address.
        add_field(ffilt_pkg::FT_IPV4_SRC_ADDR, 32'h0A01_0203, 32'd0, 32'd0, 1'b1);
        add_field(ffilt_pkg::FT_IPV4_SRC_ADDR, 32'h0A01_02FF, 32'd0, 32'd0, 1'b1);
        add_field(ffilt_pkg::FT_IPV4_SRC_ADDR, 32'h0A01_0305, 32'd0, 32'd0, 1'b1);
        add_field(ffilt_pkg::FT_IPV4_DST_ADDR, 32'hC0A8_FFFF, 32'd0, 32'd0, 1'b0);
        add_field(ffilt_pkg::FT_L4_DST_PORT, 32'hFFFF_01BB, 32'd0, 32'd0, 1'b0);
        add_field(ffilt_pkg::FT_L4_SRC_PORT, 32'h0000_0050, 32'd0, 32'd0, 1'b1);
        add_field(ffilt_pkg::FT_L4_SRC_PORT, 32'h0000_0051, 32'd0, 32'd0, 1'b1);
        add_field(16'h0000, 32'd0, 32'd0, 32'd0, 1'b1);
        // A delta of -999 ms truncates to zero seconds; the largest positive
        // delta lands exactly on the stop bound.
        add_field(ffilt_pkg::FT_FIRST_SWITCHED, 32'd4001, 32'd5000, 32'd1_000_000, 1'b0);
        add_field(ffilt_pkg::FT_LAST_SWITCHED, 32'h7FFF_FFFF, 32'd0,
                  32'd1_000_100 - 32'd2147483, 1'b1);
        add_field(ffilt_pkg::FT_FIRST_SWITCHED, 32'd0, 32'd1000, 32'd1_000_000, 1'b1);
        // Most negative delta, one second past the stop bound.
        add_field(ffilt_pkg::FT_LAST_SWITCHED, 32'd0, 32'h8000_0000,
                  32'd1_000_101 + 32'd2147483, 1'b1);
        // The drop flag must stick across the rest of the record.
        add_field(ffilt_pkg::FT_L4_SRC_PORT, 32'd81, 32'd0, 32'd0, 1'b0);
        add_field(ffilt_pkg::FT_IPV4_DST_ADDR, 32'hC0A8_0001, 32'd0, 32'd0, 1'b1);
        wait_drained();

        // Extreme settings: all zero, then everything enabled at its top value.
        run_random_phase('0, PHASE_FIELDS / 2, 4);
        plan = '{src_addr: 32'hFFFF_FFFE, src_mask: ffilt_pkg::ALL_ONES32,
                 dst_addr: 32'hFFFF_FFFE, dst_mask: 32'hFFFF_FFFE,
                 win_start: 32'hFFFF_FFFE, win_stop: 32'hFFFF_FFFE,
                 src_port: 16'hFFFE, dst_port: 16'hFFFE};
        run_random_phase(plan, PHASE_FIELDS / 2, 4);

        // Single-field records while the receiver holds off fill the output side.
        plan = random_filter();
        load_filter(plan);
        hold_requests++;
        for (int i = 0; i < 60; i++)
            add_random_record(plan, 1);
        wait_drained();

        idle_pct = 0;
        run_random_phase(random_filter(), PHASE_FIELDS, 6);
        idle_pct = IDLE_PERCENT;
        for (int p = 0; p < 5; p++)
            run_random_phase(random_filter(), PHASE_FIELDS, 6);
        run_random_phase(random_filter(), PHASE_FIELDS, 12);

        $display("Sent %0d field beats across directed, extreme and random filter settings.",
                 fields_taken);
        $display("Checked %0d records: %0d passed, %0d dropped.",
                 records_passed + records_dropped, records_passed, records_dropped);
        if (error_count == 0 && verdicts_due.size() == 0) begin
            $display("** flow_record_field_filter_top: PASSED **");
        end else begin
            $display("** flow_record_field_filter_top: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d verdicts outstanding.", verdicts_due.size());
        $display("** flow_record_field_filter_top: FAILED **");
        $finish;
    end

endmodule
